>>> rtl/sm4rc_pkg.sv
// Package for the SM4-structured round cipher: beat types, action codes and
// the round function helpers (substitution and linear mix).
// Depends on nothing; used by sm4_style_round_cipher.
package sm4rc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned KeyDepth = 32;
  localparam int unsigned KeyAw  = 5;

  // Action codes carried in the input beat.
  localparam logic ActLoadKey = 1'b0;
  localparam logic ActEncrypt = 1'b1;

  // Each byte of the round input is XORed with this before the linear mix.
  localparam logic [WordW-1:0] SubMask = 32'hA5A5_A5A5;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic             action;
    logic [KeyAw-1:0] key_index;
    word_t            key_word;
    word_t            word0;
    word_t            word1;
    word_t            word2;
    word_t            word3;
  } in_t;

  typedef struct packed {
    word_t out0;
    word_t out1;
    word_t out2;
    word_t out3;
  } out_t;

  // Simplified substitution: every byte XOR 0xA5.
  function automatic word_t sm4rc_sub(input word_t v);
    return v ^ SubMask;
  endfunction

  // SM4 linear transform L: B ^ rotl2 ^ rotl10 ^ rotl18 ^ rotl24.
  function automatic word_t sm4rc_mix(input word_t b);
    word_t r2, r10, r18, r24;
    r2  = {b[29:0], b[31:30]};
    r10 = {b[21:0], b[31:22]};
    r18 = {b[13:0], b[31:14]};
    r24 = {b[7:0],  b[31:8]};
    return b ^ r2 ^ r10 ^ r18 ^ r24;
  endfunction

endpackage

>>> rtl/sm4_style_round_cipher.sv
// Top level of the SM4-structured round cipher: round-key store, round
// sequencer, one shared round unit and the output register.
// Depends on sm4rc_pkg for beat types, action codes and round helpers.

// Each input beat either loads one 32-bit round key into a 32-entry store
// (no result) or encrypts a 128-bit block given as four words. An encrypt
// beat occupies the block for its rounds and the finish state: one shared
// round unit computes one round per cycle, fed by the key store whose
// registered read port fetches the next round's key while the current
// round runs, and the finish state then moves the finished words into the
// output register. The input side is ready only while idle, so key loads
// and the next block may be accepted while a finished result still waits
// in the output register; a second result then waits in the round
// registers until the first has been taken. Round i uses key i, so every
// key that a block will read must be loaded before the block is sent; the
// store has no reset and unloaded entries read as arbitrary values. The
// substitution is a byte-wise XOR with 0xA5 followed by the SM4 linear
// mix; there is no standard S-box, no key schedule and no final word
// reversal, so the result words leave in state order.
module sm4_style_round_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sm4rc_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sm4rc_pkg::out_t  out_data_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRound,
    StFinish
  } state_e;

  localparam logic [sm4rc_pkg::KeyAw-1:0] LastRound = sm4rc_pkg::KeyAw'(ROUNDS - 1);

  state_e                        state_q, state_d;
  logic [sm4rc_pkg::KeyAw-1:0]   rnd_q, rnd_d;
  logic                          out_valid_q, out_valid_d;
  sm4rc_pkg::out_t               out_data_q, out_data_d;

  sm4rc_pkg::word_t              w0_q, w1_q, w2_q, w3_q;
  sm4rc_pkg::word_t              key_rd_q;
  sm4rc_pkg::word_t              key_mem [sm4rc_pkg::KeyDepth];

  logic                          in_fire, load_fire, enc_fire;
  logic                          round_en;
  logic [sm4rc_pkg::KeyAw-1:0]   rd_addr;
  sm4rc_pkg::word_t              round_in, fresh;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (in_data_i.action == sm4rc_pkg::ActLoadKey);
  assign enc_fire   = in_fire && (in_data_i.action == sm4rc_pkg::ActEncrypt);
  assign round_en   = (state_q == StRound);

  // Key for round 0 is fetched on acceptance; during round r the key for
  // round r + 1 is fetched, wrapping naturally at the store depth.
  assign rd_addr = (state_q == StRound) ? rnd_q + 1'b1 : '0;

  // The shared round unit.
  assign round_in = w1_q ^ w2_q ^ w3_q ^ key_rd_q;
  assign fresh    = w0_q ^ sm4rc_pkg::sm4rc_mix(sm4rc_pkg::sm4rc_sub(round_in));

  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      key_mem[in_data_i.key_index] <= in_data_i.key_word;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (enc_fire) begin
      w0_q <= in_data_i.word0;
      w1_q <= in_data_i.word1;
      w2_q <= in_data_i.word2;
      w3_q <= in_data_i.word3;
    end else if (round_en) begin
      w0_q <= w1_q;
      w1_q <= w2_q;
      w2_q <= w3_q;
      w3_q <= fresh;
    end
  end

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (enc_fire) begin
          rnd_d   = '0;
          state_d = StRound;
        end
      end
      StRound: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == LastRound) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = '{out0: w0_q, out1: w1_q, out2: w2_q, out3: w3_q};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> dv/tb.sv
// Self-checking testbench for sm4_style_round_cipher: random and directed key loads and
// block encryptions, with every result checked against a cycle-free model of the rounds.
// Depends on sm4rc_pkg for the beat types, the action codes and the substitution mask.

module tb;

  localparam int unsigned CipherRounds = 32;
  // An encryption holds the block through its rounds and the registering of the result.
  localparam int unsigned BlockLatency = CipherRounds + 1;
  localparam int unsigned RandomBeats = 1000;
  localparam int unsigned IdlePercent = 28;

  // Expected ciphertexts in arrival order, worked out from a private copy of the key store.
  class cipher_scoreboard;
    sm4rc_pkg::word_t round_key_copy [sm4rc_pkg::KeyDepth];
    sm4rc_pkg::out_t ciphertext_q [$];
    int unsigned mismatch_count = 0;

    function sm4rc_pkg::word_t rotl(sm4rc_pkg::word_t v, int unsigned s);
      return (v << s) | (v >> (sm4rc_pkg::WordW - s));
    endfunction

    function sm4rc_pkg::out_t encipher(sm4rc_pkg::in_t blk);
      sm4rc_pkg::word_t w [4];
      sm4rc_pkg::word_t t;
      sm4rc_pkg::word_t fresh;
      sm4rc_pkg::out_t res;
      w = '{blk.word0, blk.word1, blk.word2, blk.word3};
      for (int unsigned r = 0; r < CipherRounds; r++) begin
        t = w[1] ^ w[2] ^ w[3]
            ^ round_key_copy[sm4rc_pkg::KeyAw'(r % sm4rc_pkg::KeyDepth)];
        t = t ^ sm4rc_pkg::SubMask;
        fresh = w[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
        w = '{w[1], w[2], w[3], fresh};
      end
      res.out0 = w[0];
      res.out1 = w[1];
      res.out2 = w[2];
      res.out3 = w[3];
      return res;
    endfunction

    // Called for every input beat the block accepts.
    function void note_beat(sm4rc_pkg::in_t beat);
      if (beat.action == sm4rc_pkg::ActLoadKey) begin
        round_key_copy[beat.key_index] = beat.key_word;
      end else begin
        ciphertext_q.push_back(encipher(beat));
      end
    endfunction

    // Called for every result beat the block hands over.
    function void check_result(sm4rc_pkg::out_t got);
      string field_name [4] = '{"out0", "out1", "out2", "out3"};
      sm4rc_pkg::out_t want;
      sm4rc_pkg::word_t want_w [4];
      sm4rc_pkg::word_t got_w [4];
      if (ciphertext_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatch_count++;
        return;
      end
      want = ciphertext_q.pop_front();
      want_w = '{want.out0, want.out1, want.out2, want.out3};
      got_w = '{got.out0, got.out1, got.out2, got.out3};
      for (int i = 0; i < 4; i++) begin
        if (got_w[i] !== want_w[i]) begin
          $error("%s: expected %h, got %h", field_name[i], want_w[i], got_w[i]);
          mismatch_count++;
        end
      end
    endfunction

    function int unsigned pending();
      return ciphertext_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sm4rc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sm4rc_pkg::out_t out_data_o;

  // While set, neither side idles, so the block is driven at its full rate.
  bit steady_phase = 1'b0;

  cipher_scoreboard beats = new();

  sm4_style_round_cipher #(
    .ROUNDS(CipherRounds)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The receiver stalls at random, except during the steady phase.
  always @(negedge clk_i) begin
    out_ready_i <= steady_phase || ($urandom_range(99) >= IdlePercent);
  end

  // Result beats are taken at the rising edge where valid and ready are both high.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats.check_result(out_data_o);
    end
  end

  // Presents one input beat and returns at the edge where it is accepted. Valid is
  // only ever changed once per falling edge, and stays high while the beat waits.
  task automatic send_beat(input sm4rc_pkg::in_t beat);
    @(negedge clk_i);
    while (!steady_phase && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    beats.note_beat(beat);
  endtask

  // The block words of a load are ignored, so they are filled with noise.
  task automatic load_key(input logic [sm4rc_pkg::KeyAw-1:0] idx,
                          input sm4rc_pkg::word_t value);
    sm4rc_pkg::in_t beat;
    beat.action = sm4rc_pkg::ActLoadKey;
    beat.key_index = idx;
    beat.key_word = value;
    beat.word0 = $urandom();
    beat.word1 = $urandom();
    beat.word2 = $urandom();
    beat.word3 = $urandom();
    send_beat(beat);
  endtask

  // Likewise the key fields of an encryption are ignored and carry noise.
  task automatic encrypt_block(input sm4rc_pkg::word_t w0, input sm4rc_pkg::word_t w1,
                               input sm4rc_pkg::word_t w2, input sm4rc_pkg::word_t w3);
    sm4rc_pkg::in_t beat;
    beat.action = sm4rc_pkg::ActEncrypt;
    beat.key_index = sm4rc_pkg::KeyAw'($urandom_range(sm4rc_pkg::KeyDepth - 1));
    beat.key_word = $urandom();
    beat.word0 = w0;
    beat.word1 = w1;
    beat.word2 = w2;
    beat.word3 = w3;
    send_beat(beat);
  endtask

  // Random word, biased towards the all-zero and all-one extremes.
  function automatic sm4rc_pkg::word_t pick_word();
    int unsigned roll;
    roll = $urandom_range(15);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return $urandom();
  endfunction

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every round reads its key, so the whole store is filled before the first block.
    // The first and last entries take the extreme values, and one entry takes the
    // substitution mask so that it cancels inside the round.
    for (int unsigned k = 0; k < sm4rc_pkg::KeyDepth; k++) begin
      if (k == 0) begin
        load_key(sm4rc_pkg::KeyAw'(k), '0);
      end else if (k == sm4rc_pkg::KeyDepth - 1) begin
        load_key(sm4rc_pkg::KeyAw'(k), '1);
      end else if (k == 16) begin
        load_key(sm4rc_pkg::KeyAw'(k), sm4rc_pkg::SubMask);
      end else begin
        load_key(sm4rc_pkg::KeyAw'(k), $urandom());
      end
    end

    // Directed blocks: extreme and patterned words, then keys changed at both ends
    // of the store between blocks.
    encrypt_block('0, '0, '0, '0);
    encrypt_block('1, '1, '1, '1);
    encrypt_block(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    load_key('0, '1);
    load_key(sm4rc_pkg::KeyAw'(sm4rc_pkg::KeyDepth - 1), '0);
    encrypt_block('0, '1, '0, '1);
    load_key(sm4rc_pkg::KeyAw'(5), sm4rc_pkg::SubMask);
    encrypt_block(sm4rc_pkg::SubMask, sm4rc_pkg::SubMask, sm4rc_pkg::SubMask,
                  sm4rc_pkg::SubMask);
    encrypt_block($urandom(), $urandom(), $urandom(), $urandom());
    encrypt_block($urandom(), $urandom(), $urandom(), $urandom());

    // Random mix of key loads and blocks; a window in the middle runs without idling.
    for (int unsigned n = 0; n < RandomBeats; n++) begin
      steady_phase = (n >= 400 && n < 600);
      if ($urandom_range(99) < 40) begin
        load_key(sm4rc_pkg::KeyAw'($urandom_range(sm4rc_pkg::KeyDepth - 1)), pick_word());
      end else begin
        encrypt_block(pick_word(), pick_word(), pick_word(), pick_word());
      end
    end
    steady_phase = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (beats.pending() != 0) @(posedge clk_i);
    // Anything the block still emits now would be an unexpected result.
    repeat (2 * BlockLatency) @(posedge clk_i);

    if (beats.mismatch_count == 0 && beats.pending() == 0) begin
      $display("[sm4_style_round_cipher] OK");
    end else begin
      $display("[sm4_style_round_cipher] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("[sm4_style_round_cipher] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/sm4rc_pkg.sv
rtl/sm4_style_round_cipher.sv
dv/tb.sv
